### src/sidta_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, state types and the BCD helper functions.
// No dependencies.
package sidta_pkg;

  // Width of the signed input value (8 to 64).
  localparam int unsigned VALUE_BITS = 32;
  // Input beat width, rounded up to whole bytes.
  localparam int unsigned S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
  // Decimal digits needed for a magnitude up to 2^VALUE_BITS - 1.
  localparam int unsigned BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_BITS = BCD_DIGITS * 4;
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int unsigned DIG_CNT_W = $clog2(BCD_DIGITS + 1);

  localparam int unsigned CHAR_W = 8;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } sidta_conv_e;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SIGN,
    EMIT_SKIP,
    EMIT_DIGIT
  } sidta_emit_e;

  // Finished conversion handed from the converter to the character emitter.
  typedef struct packed {
    logic                neg;
    logic [BCD_BITS-1:0] bcd;
  } sidta_bcd_t;

  // Double-dabble correction: every digit of five or more gets three added.
  function automatic logic [BCD_BITS-1:0] bcd_add3(input logic [BCD_BITS-1:0] bcd);
    logic [BCD_BITS-1:0] res;
    res = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // True when every digit of the word is a legal decimal digit.
  function automatic logic bcd_legal(input logic [BCD_BITS-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

### src/sidta_b2bcd.sv
// Bit-serial binary to BCD converter (shift and add three, one bit per cycle).
// Depends on sidta_pkg.
module sidta_b2bcd (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [sidta_pkg::VALUE_BITS-1:0]    in_value_i,
  output logic                                in_ready_o,
  output logic                                out_valid_o,
  output sidta_pkg::sidta_bcd_t               out_data_o,
  input  logic                                out_ready_i
);

  sidta_pkg::sidta_conv_e state_q, state_d;
  logic [sidta_pkg::VALUE_BITS-1:0] mag_q, mag_d;
  logic [sidta_pkg::BCD_BITS-1:0]   bcd_q, bcd_d, bcd_adj;
  logic                             neg_q, neg_d;
  logic [sidta_pkg::BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic                             take;

  assign take    = in_valid_i && in_ready_o;
  assign bcd_adj = sidta_pkg::bcd_add3(bcd_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sidta_pkg::CONV_IDLE: begin
        if (in_valid_i) begin
          state_d = sidta_pkg::CONV_RUN;
        end
      end
      sidta_pkg::CONV_RUN: begin
        if (bit_cnt_q == '0) begin
          state_d = sidta_pkg::CONV_DONE;
        end
      end
      sidta_pkg::CONV_DONE: begin
        if (out_ready_i) begin
          state_d = sidta_pkg::CONV_IDLE;
        end
      end
      default: state_d = sidta_pkg::CONV_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == sidta_pkg::CONV_IDLE);
    out_valid_o = (state_q == sidta_pkg::CONV_DONE);
    out_data_o.neg = neg_q;
    out_data_o.bcd = bcd_q;
  end

  always_comb begin
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    bit_cnt_d = bit_cnt_q;
    if (take) begin
      // The negation wraps the most negative value onto its own bit pattern,
      // which read unsigned is exactly the wanted magnitude.
      neg_d     = in_value_i[sidta_pkg::VALUE_BITS-1];
      mag_d     = neg_d ? (~in_value_i + 1'b1) : in_value_i;
      bcd_d     = '0;
      bit_cnt_d = sidta_pkg::BIT_CNT_W'(sidta_pkg::VALUE_BITS - 1);
    end else if (state_q == sidta_pkg::CONV_RUN) begin
      bcd_d     = {bcd_adj[sidta_pkg::BCD_BITS-2:0], mag_q[sidta_pkg::VALUE_BITS-1]};
      mag_d     = {mag_q[sidta_pkg::VALUE_BITS-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sidta_pkg::CONV_IDLE;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidta_pkg::CONV_RUN && bit_cnt_q == '0) |=> (state_q == sidta_pkg::CONV_DONE))
    else $error("converter did not finish after the last bit");

  a_bcd_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidta_pkg::CONV_DONE) |-> sidta_pkg::bcd_legal(bcd_q))
    else $error("converter produced an illegal BCD digit");

endmodule

### src/sidta_emit.sv
// Character emitter: shifts BCD digits out as ASCII, one nibble per cycle while the output register is free.
// Depends on sidta_pkg.
module sidta_emit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  sidta_pkg::sidta_bcd_t             in_data_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  output logic [sidta_pkg::CHAR_W-1:0]      out_char_o,
  output logic                              out_last_o,
  input  logic                              out_ready_i
);

  sidta_pkg::sidta_emit_e state_q, state_d;
  logic [sidta_pkg::BCD_BITS-1:0]  bcd_q, bcd_d;
  logic [sidta_pkg::DIG_CNT_W-1:0] cnt_q, cnt_d;
  logic                            valid_q, valid_d;
  logic [sidta_pkg::CHAR_W-1:0]    char_q, char_d;
  logic                            last_q, last_d;
  logic [3:0]                      top_nib;
  logic                            out_free, take, emit, emit_last, shift;
  logic [sidta_pkg::CHAR_W-1:0]    emit_char;

  assign top_nib  = bcd_q[sidta_pkg::BCD_BITS-1 -: 4];
  assign out_free = !valid_q || out_ready_i;
  assign take     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sidta_pkg::EMIT_IDLE: begin
        if (in_valid_i) begin
          state_d = in_data_i.neg ? sidta_pkg::EMIT_SIGN : sidta_pkg::EMIT_SKIP;
        end
      end
      sidta_pkg::EMIT_SIGN: begin
        if (out_free) begin
          state_d = sidta_pkg::EMIT_SKIP;
        end
      end
      sidta_pkg::EMIT_SKIP: begin
        if (top_nib != 4'd0 || cnt_q == sidta_pkg::DIG_CNT_W'(1)) begin
          state_d = sidta_pkg::EMIT_DIGIT;
        end
      end
      sidta_pkg::EMIT_DIGIT: begin
        if (out_free && cnt_q == sidta_pkg::DIG_CNT_W'(1)) begin
          state_d = sidta_pkg::EMIT_IDLE;
        end
      end
      default: state_d = sidta_pkg::EMIT_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == sidta_pkg::EMIT_IDLE);
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_char  = sidta_pkg::ASCII_ZERO + {4'd0, top_nib};
    shift      = 1'b0;
    case (state_q)
      sidta_pkg::EMIT_SIGN: begin
        emit      = out_free;
        emit_char = sidta_pkg::ASCII_MINUS;
      end
      sidta_pkg::EMIT_SKIP: begin
        shift = (top_nib == 4'd0) && (cnt_q != sidta_pkg::DIG_CNT_W'(1));
      end
      sidta_pkg::EMIT_DIGIT: begin
        emit      = out_free;
        emit_last = (cnt_q == sidta_pkg::DIG_CNT_W'(1));
        shift     = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    valid_d = valid_q && !out_ready_i;
    char_d  = char_q;
    last_d  = last_q;
    if (take) begin
      bcd_d = in_data_i.bcd;
      cnt_d = sidta_pkg::DIG_CNT_W'(sidta_pkg::BCD_DIGITS);
    end else if (shift) begin
      bcd_d = {bcd_q[sidta_pkg::BCD_BITS-5:0], 4'd0};
      cnt_d = cnt_q - 1'b1;
    end
    if (emit) begin
      valid_d = 1'b1;
      char_d  = emit_char;
      last_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sidta_pkg::EMIT_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sidta_pkg::EMIT_IDLE) |-> (cnt_q != '0))
    else $error("emitter busy with no digits left");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (char_q == sidta_pkg::ASCII_MINUS ||
                 (char_q >= sidta_pkg::ASCII_ZERO && char_q <= sidta_pkg::ASCII_NINE)))
    else $error("emitter produced a character outside the digit set");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && char_q == sidta_pkg::ASCII_MINUS) |-> !last_q)
    else $error("minus sign flagged as last character");

endmodule

### src/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII top level over sidta_b2bcd and sidta_emit; uses sidta_pkg.
// The converter can take a new value while the emitter is still sending the text of the
// last one; the rate is set by the shift-and-add-three loop that takes one input bit per
// cycle, as long as the sink keeps up.
// Reset (rst_ni low, asynchronous) empties both stages and drops any pending characters.
module signed_int_to_decimal_ascii (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input beat: [VALUE_BITS-1:0] value (signed), upper bits zero padding.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [sidta_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // Output beat: [7:0] ascii_char.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [sidta_pkg::CHAR_W-1:0]       m_axis_tdata_o,
  // last_char: high on the final character of a value's text.
  output logic                               m_axis_tlast_o
);

  // The converter takes a value, strips the sign, and runs the magnitude through
  // the double-dabble shift register one bit per cycle. The finished BCD word and
  // sign then pass to the emitter while the converter is free for the next value.
  logic                  conv_valid;
  logic                  conv_ready;
  sidta_pkg::sidta_bcd_t conv_data;
  logic [sidta_pkg::VALUE_BITS-1:0] value;

  // Bits above the value field are padding and are ignored.
  assign value = s_axis_tdata_i[sidta_pkg::VALUE_BITS-1:0];

  sidta_b2bcd u_b2bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_value_i  (value),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (conv_valid),
    .out_data_o  (conv_data),
    .out_ready_i (conv_ready)
  );

  // The emitter sends the sign first for negative values, drops leading zeros
  // (keeping the final digit, so zero prints as one '0'), and then shifts out one
  // digit per beat through an output register that holds under backpressure.
  sidta_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (conv_valid),
    .in_data_i   (conv_data),
    .in_ready_o  (conv_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule

### test/decimal_text_checker.sv
// Checker for the signed integer to decimal ASCII converter: watches both stream channels,
// predicts the characters of every accepted value and compares them beat by beat.
// Depends on sidta_pkg for the value width and the character codes.
module decimal_text_checker
  import sidta_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [CHAR_W-1:0]    m_tdata_i,
  input  logic                 m_tlast_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int unsigned DECIMAL_BASE = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;
  } text_char_t;

  text_char_t expected_chars[$];
  int         fail_count = 0;
  int         pending    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Spells the value in decimal, sign first, and queues one character per output beat.
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] raw);
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            digits[$];
    text_char_t            c;
    negative  = raw[VALUE_BITS-1];
    // The two's complement of the most negative value reads correctly as unsigned.
    magnitude = negative ? (~raw + 1'b1) : raw;
    if (magnitude == '0) begin
      c.ascii_char = ASCII_ZERO;
      c.last_char  = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    while (magnitude != '0) begin
      digits.push_front(4'(magnitude % DECIMAL_BASE));
      magnitude = magnitude / DECIMAL_BASE;
    end
    if (negative) begin
      c.ascii_char = ASCII_MINUS;
      c.last_char  = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.ascii_char = ASCII_ZERO + CHAR_W'(digits[i]);
      c.last_char  = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        queue_decimal_text(s_tdata_i[VALUE_BITS-1:0]);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                    m_tdata_i, m_tlast_i));
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata_i !== want.ascii_char) begin
            report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                      m_tdata_i, want.ascii_char));
          end
          if (m_tlast_i !== want.last_char) begin
            report_mismatch($sformatf("last flag %0b, wanted %0b on character 0x%02h",
                                      m_tlast_i, want.last_char, want.ascii_char));
          end
        end
      end
      pending = expected_chars.size();
    end
  end

endmodule

### test/testbench.sv
// Top of the testbench for signed_int_to_decimal_ascii: clock, reset, value stimulus,
// output back-pressure and the verdict. Depends on sidta_pkg, the converter and
// decimal_text_checker, which does all prediction and comparison.
module testbench;
  import sidta_pkg::*;

  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_COUNT = 82;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [CHAR_W-1:0]    m_tdata;
  logic                 m_tlast;

  int fail_count;
  int pending;
  int cycles = 0;
  // Percent of cycles in which the sender and the receiver hold back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  signed_int_to_decimal_ascii dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  decimal_text_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The receiver decides its ready once per cycle, on the falling edge, so the
  // converter sees a stable value at every rising edge.
  always @(negedge clk_i) begin
    m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offers one value beat. Called at a falling edge and returns at one. The valid
  // is only lowered for an idle gap, so back-to-back beats keep it high throughout.
  task automatic offer_value(input logic [VALUE_BITS-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = S_TDATA_W'($urandom);
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    // The padding above the value stays zero.
    s_tdata  = S_TDATA_W'(value);
    do begin
      @(posedge clk_i);
    end while (!s_tready);
    @(negedge clk_i);
  endtask

  // Holds the sender back until every character already owed has come out.
  task automatic drain_text();
    s_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Random values of every length: raw words, sign-extended words shifted down to
  // fewer digits, neighbors of powers of ten, and the extremes of the range.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [63:0]                  wide;
    logic signed [VALUE_BITS-1:0] shifted;
    longint                       power;
    logic [VALUE_BITS-1:0]        value;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: begin
        value = wide[VALUE_BITS-1:0];
      end
      1: begin
        shifted = wide[VALUE_BITS-1:0];
        value   = shifted >>> $urandom_range(0, VALUE_BITS - 1);
      end
      2: begin
        power = 1;
        repeat ($urandom_range(0, 9)) power = power * 10;
        power = power + $urandom_range(0, 2) - 1;
        value = $urandom_range(0, 1) ? VALUE_BITS'(-power) : VALUE_BITS'(power);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: value = {1'b1, {(VALUE_BITS - 1){1'b0}}};
          1: value = {1'b0, {(VALUE_BITS - 1){1'b1}}};
          2: value = {1'b1, {(VALUE_BITS - 2){1'b0}}, 1'b1};
          3: value = '1;
          default: value = '0;
        endcase
      end
    endcase
    return value;
  endfunction

  initial begin
    logic [VALUE_BITS-1:0] directed[$];

    // Zero, single digits of both signs, digit-count boundaries, the largest
    // value, the most negative value and its neighbor, and alternating bits.
    directed.push_back('0);
    directed.push_back(VALUE_BITS'(1));
    directed.push_back('1);
    directed.push_back(VALUE_BITS'(9));
    directed.push_back(VALUE_BITS'(-9));
    directed.push_back(VALUE_BITS'(10));
    directed.push_back(VALUE_BITS'(-10));
    directed.push_back(VALUE_BITS'(99));
    directed.push_back(VALUE_BITS'(100));
    directed.push_back(VALUE_BITS'(1000000000));
    directed.push_back(VALUE_BITS'(-1000000000));
    directed.push_back({1'b0, {(VALUE_BITS - 1){1'b1}}});
    directed.push_back({1'b1, {(VALUE_BITS - 1){1'b0}}});
    directed.push_back({1'b1, {(VALUE_BITS - 2){1'b0}}, 1'b1});
    directed.push_back({(VALUE_BITS / 2){2'b01}});
    directed.push_back({(VALUE_BITS / 2){2'b10}});
    directed.push_back('0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Three phases: slow sink, then slow source, then full rate on both sides.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed[i]) offer_value(directed[i]);
        drain_text();
      end
      repeat (RANDOM_COUNT) offer_value(pick_value());
      drain_text();
    end

    // Let any stray beat show up before the verdict.
    repeat (VALUE_BITS + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
